// ----- hdl/i2c_master_pin_sequencer_assert.svh -----
// Assertion macros for the I2C pin sequencer.
// Each macro takes a label, an antecedent and a consequent, sampled on clk
// and disabled while rst_n is low.
`ifndef I2C_MASTER_PIN_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_PIN_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define I2CMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c pin sequencer: same-cycle check failed");
`define I2CMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c pin sequencer: next-cycle check failed");
`else
`define I2CMS_ASSERT_SAME(label, ante, cons)
`define I2CMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/i2cms_pkg.sv -----
`timescale 1ns / 1ps

package i2cms_pkg;

    // func codes on the input channel
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_START   = 3'd1;
    localparam logic [2:0] FUNC_RESTART = 3'd2;
    localparam logic [2:0] FUNC_STOP    = 3'd3;
    localparam logic [2:0] FUNC_WRITE   = 3'd4;
    localparam logic [2:0] FUNC_READ    = 3'd5;

    // sequence being run by the back end
    localparam logic [2:0] OP_IDLE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_WRITE   = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    // word class assigned by the front end
    localparam logic [1:0] KIND_NOP  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_CMD  = 2'd2;

    localparam int BITS        = 8;
    localparam int STEP_W      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // write sequence step numbers
    localparam logic [STEP_W-1:0] WR_DATA_END = STEP_W'(3 * BITS);
    localparam logic [STEP_W-1:0] WR_ACK_REL  = STEP_W'(3 * BITS);
    localparam logic [STEP_W-1:0] WR_ACK_HI   = STEP_W'(3 * BITS + 1);
    localparam logic [STEP_W-1:0] WR_ACK_LO   = STEP_W'(3 * BITS + 2);

    // read sequence step numbers
    localparam logic [STEP_W-1:0] RD_REL     = STEP_W'(0);
    localparam logic [STEP_W-1:0] RD_DATA_END = STEP_W'(2 * BITS);
    localparam logic [STEP_W-1:0] RD_DRIVE   = STEP_W'(2 * BITS + 1);
    localparam logic [STEP_W-1:0] RD_ACK_SDA = STEP_W'(2 * BITS + 2);
    localparam logic [STEP_W-1:0] RD_ACK_HI  = STEP_W'(2 * BITS + 3);
    localparam logic [STEP_W-1:0] RD_ACK_LO  = STEP_W'(2 * BITS + 4);

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] op;
        logic [7:0] wdata;
        logic       ack_level;
        logic       sda_in;
    } i2cms_word_t;

endpackage

// ----- hdl/i2c_master_pin_sequencer.sv -----
// A word's result is registered at the edge that pops it from the queue.
// One word per cycle unless the output stalls; one pin step per tick word.
// A two-word queue between decode and sequencer absorbs output stalls.
// Reset (rst_n, async, active low): idle, SCL and SDA high, SDA driven,
// queue and output slot empty.
`timescale 1ns / 1ps

`include "i2c_master_pin_sequencer_assert.svh"

module i2c_master_pin_sequencer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [7:0] wdata,
    input  logic       ack_level,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl,
    output logic       sda_out,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rdata,
    output logic       ack_ok,
    output logic       rejected
);
    import i2cms_pkg::*;

    // front end -> queue
    logic        q_ready;
    logic        q_push;
    i2cms_word_t q_word;

    // queue -> sequencer
    logic        head_valid;
    i2cms_word_t head_word;
    logic        pop;

    // Front end: classifies func into tick, command or no-op.
    i2cms_front u_front
    (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .wdata     (wdata),
        .ack_level (ack_level),
        .sda_in    (sda_in),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_word    (q_word)
    );

    // Short queue decoupling the input handshake from the sequencer.
    i2cms_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_word),
        .push_ready (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    // Sequencer: loads commands, runs one pin step per tick word and holds
    // the result word until the sink takes it.
    i2cms_exec u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .scl        (scl),
        .sda_out    (sda_out),
        .sda_drive  (sda_drive),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .rdata      (rdata),
        .ack_ok     (ack_ok),
        .rejected   (rejected)
    );

    // a step that finishes a sequence cannot also reject a command
    `I2CMS_ASSERT_SAME(a_done_not_rej, out_valid && done_res, !rejected)
    // finishing a sequence leaves the sequencer idle
    `I2CMS_ASSERT_SAME(a_done_idle, out_valid && done_res, !busy_res)
    // a rejection only happens while a sequence runs
    `I2CMS_ASSERT_SAME(a_rej_busy, out_valid && rejected, busy_res)
    // every sequence ends with SDA driven again
    `I2CMS_ASSERT_SAME(a_idle_drives, !busy_res, sda_drive)
    // a word popped with the output slot stalled is impossible
    `I2CMS_ASSERT_NEXT(a_pop_slot, out_valid && !out_ready, out_valid)

endmodule

// ----- hdl/i2cms_front.sv -----
`timescale 1ns / 1ps

module i2cms_front
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            func,
    input  logic [7:0]            wdata,
    input  logic                  ack_level,
    input  logic                  sda_in,
    input  logic                  q_ready,
    output logic                  q_push,
    output i2cms_pkg::i2cms_word_t q_word
);
    import i2cms_pkg::*;

    logic [1:0] kind;

    always_comb
    begin
        unique case (func) inside
            FUNC_TICK:
                kind = KIND_TICK;
            FUNC_START, FUNC_RESTART, FUNC_STOP, FUNC_WRITE, FUNC_READ:
                kind = KIND_CMD;
            default:
                kind = KIND_NOP;
        endcase
    end

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    assign q_word.kind      = kind;
    assign q_word.op        = func;
    assign q_word.wdata     = wdata;
    assign q_word.ack_level = ack_level;
    assign q_word.sda_in    = sda_in;

endmodule

// ----- hdl/i2cms_queue.sv -----
`timescale 1ns / 1ps

module i2cms_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  i2cms_pkg::i2cms_word_t push_word,
    output logic                   push_ready,
    input  logic                   pop,
    output logic                   head_valid,
    output i2cms_pkg::i2cms_word_t head_word
);
    import i2cms_pkg::*;

    i2cms_word_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- hdl/i2cms_exec.sv -----
`timescale 1ns / 1ps

module i2cms_exec
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  i2cms_pkg::i2cms_word_t head_word,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   scl,
    output logic                   sda_out,
    output logic                   sda_drive,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [7:0]             rdata,
    output logic                   ack_ok,
    output logic                   rejected
);
    import i2cms_pkg::*;

    logic [2:0]        op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        ph_reg, ph_next;
    logic [7:0]        shift_reg, shift_next;
    logic              hold_ack_reg, hold_ack_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              dir_reg, dir_next;
    logic [7:0]        rdata_reg, rdata_next;
    logic              ack_ok_reg, ack_ok_next;
    logic              done_reg, done_next;
    logic              rej_reg, rej_next;
    logic              out_valid_reg, out_valid_next;
    logic              busy;
    logic              last;
    logic [STEP_W-1:0] start_k;

    assign busy    = op_reg != OP_IDLE;
    assign pop     = head_valid && (!out_valid_reg || out_ready);
    assign start_k = (op_reg == OP_RESTART) ? step_reg - 1'b1 : step_reg;

    always_comb
    begin
        op_next       = op_reg;
        step_next     = step_reg;
        ph_next       = ph_reg;
        shift_next    = shift_reg;
        hold_ack_next = hold_ack_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        dir_next      = dir_reg;
        rdata_next    = rdata_reg;
        ack_ok_next   = ack_ok_reg;
        rej_next      = 1'b0;
        last          = 1'b0;

        if (head_word.kind == KIND_TICK && busy)
        begin
            unique case (op_reg) inside
                OP_START, OP_RESTART:
                begin
                    if (op_reg == OP_RESTART && step_reg == '0)
                    begin
                        dir_next = 1'b1;
                    end
                    else if (start_k == STEP_W'(0))
                    begin
                        sda_next = 1'b1;
                    end
                    else if (start_k == STEP_W'(1))
                    begin
                        scl_next = 1'b1;
                    end
                    else if (start_k == STEP_W'(2))
                    begin
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        last     = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    if (step_reg == STEP_W'(0))
                    begin
                        sda_next = 1'b0;
                    end
                    else if (step_reg == STEP_W'(1))
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        sda_next = 1'b1;
                        last     = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    if (step_reg < WR_DATA_END)
                    begin
                        // three steps per bit: data, SCL high, SCL low and shift
                        ph_next = (ph_reg == 2'd2) ? 2'd0 : ph_reg + 1'b1;
                        if (ph_reg == 2'd0)
                        begin
                            sda_next = shift_reg[7];
                        end
                        else if (ph_reg == 2'd1)
                        begin
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                    end
                    else if (step_reg == WR_ACK_REL)
                    begin
                        dir_next = 1'b0;
                    end
                    else if (step_reg == WR_ACK_HI)
                    begin
                        scl_next    = 1'b1;
                        ack_ok_next = !head_word.sda_in;
                    end
                    else if (step_reg == WR_ACK_LO)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        dir_next = 1'b1;
                        last     = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (step_reg == RD_REL)
                    begin
                        dir_next = 1'b0;
                    end
                    else if (step_reg <= RD_DATA_END)
                    begin
                        // odd steps raise SCL and sample, even steps lower it
                        if (step_reg[0])
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], head_word.sda_in};
                        end
                        else
                        begin
                            scl_next = 1'b0;
                        end
                    end
                    else if (step_reg == RD_DRIVE)
                    begin
                        dir_next = 1'b1;
                    end
                    else if (step_reg == RD_ACK_SDA)
                    begin
                        sda_next = hold_ack_reg;
                    end
                    else if (step_reg == RD_ACK_HI)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (step_reg == RD_ACK_LO)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        sda_next   = 1'b1;
                        rdata_next = shift_reg;
                        last       = 1'b1;
                    end
                end
                default:
                begin
                    last = 1'b1;
                end
            endcase

            if (last)
            begin
                op_next   = OP_IDLE;
                step_next = '0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
        else if (head_word.kind == KIND_CMD)
        begin
            if (busy)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                op_next   = head_word.op;
                step_next = '0;
                ph_next   = 2'd0;
                if (head_word.op == OP_WRITE)
                begin
                    shift_next = head_word.wdata;
                end
                if (head_word.op == OP_READ)
                begin
                    shift_next    = '0;
                    hold_ack_next = head_word.ack_level;
                end
            end
        end

        done_next = last;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_IDLE;
            step_reg      <= '0;
            ph_reg        <= 2'd0;
            shift_reg     <= '0;
            hold_ack_reg  <= 1'b1;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            dir_reg       <= 1'b1;
            rdata_reg     <= '0;
            ack_ok_reg    <= 1'b0;
            done_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                op_reg       <= op_next;
                step_reg     <= step_next;
                ph_reg       <= ph_next;
                shift_reg    <= shift_next;
                hold_ack_reg <= hold_ack_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                dir_reg      <= dir_next;
                rdata_reg    <= rdata_next;
                ack_ok_reg   <= ack_ok_next;
                done_reg     <= done_next;
                rej_reg      <= rej_next;
            end
        end
    end

    // state only moves on pop, and pop waits for the output slot, so the
    // state registers double as the output word
    assign out_valid = out_valid_reg;
    assign scl       = scl_reg;
    assign sda_out   = sda_reg;
    assign sda_drive = dir_reg;
    assign busy_res  = busy;
    assign done_res  = done_reg;
    assign rdata     = rdata_reg;
    assign ack_ok    = ack_ok_reg;
    assign rejected  = rej_reg;

endmodule

// ----- dv/tb_i2c_master_pin_sequencer.sv -----
`timescale 1ns / 1ps

module tb_i2c_master_pin_sequencer;

    import i2cms_pkg::*;

    // func codes the block must ignore without flagging
    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;

    // pin steps per command, counted in tick words
    localparam int LEN_START   = 4;
    localparam int LEN_RESTART = 5;
    localparam int LEN_STOP    = 3;
    localparam int LEN_WRITE   = 3 * BITS + 4;
    localparam int LEN_READ    = 2 * BITS + 6;

    localparam int RANDOM_WORDS  = 740;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_AFTER    = 200;   // words sent before the long output stall
    localparam int HOLD_CYCLES   = 300;

    // one result word, in port order
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic       ack_ok;
        logic       rejected;
    } pin_result_t;

    // results that follow directly from the reset state
    localparam pin_result_t RES_RESET       = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam pin_result_t RES_LOADED      = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam pin_result_t RES_REJECT_IDLE = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};
    // command rejected during a write loaded after a start: SCL and SDA low, SDA driven
    localparam pin_result_t RES_REJECT_LOW  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};

    typedef struct {
        logic [2:0]  f;
        logic [7:0]  w;
        logic        a;
        logic        s;
        int          reps;
        bit          typed;
        pin_result_t res;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] func;
    logic [7:0] wdata;
    logic       ack_level;
    logic       sda_in;
    logic       out_valid;
    logic       out_ready;
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       ack_ok;
    logic       rejected;

    // shadow copy of the sequencer
    logic [2:0] seq_op;
    logic [5:0] seq_step;
    logic [7:0] shifter;
    logic       ack_hold;
    logic       pin_scl;
    logic       pin_sda;
    logic       pin_drive;
    logic [7:0] rd_byte;
    logic       wr_ack_ok;

    pin_result_t expected_results[$];
    stim_row_t   stim_table[$];
    int          fail_count = 0;
    int          words_sent = 0;
    int          cycle_count = 0;

    i2c_master_pin_sequencer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .wdata     (wdata),
        .ack_level (ack_level),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .scl       (scl),
        .sda_out   (sda_out),
        .sda_drive (sda_drive),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .rdata     (rdata),
        .ack_ok    (ack_ok),
        .rejected  (rejected)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Runs one word through the shadow sequencer and returns the pins after it.
    // Commands only load; each tick performs one pin step of the loaded sequence.
    function automatic pin_result_t predict_word(input logic [2:0] f, input logic [7:0] w,
                                                 input logic a, input logic s);
        pin_result_t r;
        bit          was_busy;
        bit          last;
        bit          flag_done;
        bit          flag_rej;
        int          k;
        was_busy  = (seq_op != OP_IDLE);
        last      = 1'b0;
        flag_done = 1'b0;
        flag_rej  = 1'b0;
        k         = seq_step;
        if (f == FUNC_TICK)
        begin
            if (was_busy)
            begin
                case (seq_op) inside
                    OP_START, OP_RESTART:
                    begin
                        // restart first takes the SDA drive step, then runs the start steps
                        if (seq_op == OP_RESTART && k == 0)
                            pin_drive = 1'b1;
                        else
                        begin
                            if (seq_op == OP_RESTART)
                                k = k - 1;
                            if (k == 0)
                                pin_sda = 1'b1;
                            else if (k == 1)
                                pin_scl = 1'b1;
                            else if (k == 2)
                                pin_sda = 1'b0;
                            else
                            begin
                                pin_scl = 1'b0;
                                last = 1'b1;
                            end
                        end
                    end
                    OP_STOP:
                    begin
                        if (k == 0)
                            pin_sda = 1'b0;
                        else if (k == 1)
                            pin_scl = 1'b1;
                        else
                        begin
                            pin_sda = 1'b1;
                            last = 1'b1;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (k < 3 * BITS)
                        begin
                            if (k % 3 == 0)
                                pin_sda = shifter[BITS - 1 - k / 3];
                            else
                                pin_scl = (k % 3 == 1);
                        end
                        else if (k == 3 * BITS)
                            pin_drive = 1'b0;
                        else if (k == 3 * BITS + 1)
                        begin
                            pin_scl = 1'b1;
                            wr_ack_ok = (s == 1'b0);
                        end
                        else if (k == 3 * BITS + 2)
                            pin_scl = 1'b0;
                        else
                        begin
                            pin_drive = 1'b1;
                            last = 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (k == 0)
                            pin_drive = 1'b0;
                        else if (k <= 2 * BITS)
                        begin
                            if ((k - 1) % 2 == 0)
                            begin
                                pin_scl = 1'b1;
                                shifter = {shifter[6:0], s};
                            end
                            else
                                pin_scl = 1'b0;
                        end
                        else if (k == 2 * BITS + 1)
                            pin_drive = 1'b1;
                        else if (k == 2 * BITS + 2)
                            pin_sda = ack_hold;
                        else if (k == 2 * BITS + 3)
                            pin_scl = 1'b1;
                        else if (k == 2 * BITS + 4)
                            pin_scl = 1'b0;
                        else
                        begin
                            pin_sda = 1'b1;
                            rd_byte = shifter;
                            last = 1'b1;
                        end
                    end
                    default:
                        last = 1'b1;
                endcase
                if (last)
                begin
                    seq_op   = OP_IDLE;
                    seq_step = '0;
                end
                else
                    seq_step = seq_step + 6'd1;
                flag_done = last;
            end
        end
        else if (f <= FUNC_READ)
        begin
            if (was_busy)
                flag_rej = 1'b1;
            else
            begin
                seq_op   = f;
                seq_step = '0;
                if (f == FUNC_WRITE)
                    shifter = w;
                if (f == FUNC_READ)
                begin
                    shifter  = '0;
                    ack_hold = a;
                end
            end
        end
        r.scl       = pin_scl;
        r.sda_out   = pin_sda;
        r.sda_drive = pin_drive;
        r.busy      = (seq_op != OP_IDLE);
        r.done      = flag_done;
        r.rdata     = rd_byte;
        r.ack_ok    = wr_ack_ok;
        r.rejected  = flag_rej;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic add_row(input logic [2:0] f, input logic [7:0] w, input logic a,
                           input logic s, input int reps, input bit typed,
                           input pin_result_t res);
        stim_row_t row;
        row.f     = f;
        row.w     = w;
        row.a     = a;
        row.s     = s;
        row.reps  = reps;
        row.typed = typed;
        row.res   = res;
        stim_table.push_back(row);
    endtask

    // Offers one word after a random gap and holds it until accepted.
    // The prediction is made at the accepting edge so queue order follows acceptance.
    task automatic send_word(input logic [2:0] f, input logic [7:0] w, input logic a,
                             input logic s, input bit typed, input pin_result_t typed_res);
        int          gap;
        int          r;
        pin_result_t pred;
        r = $urandom_range(0, 99);
        if (r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        // every fourth block of 64 words goes back to back
        if ((words_sent / 64) % 4 == 3)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        wdata     <= w;
        ack_level <= a;
        sda_in    <= s;
        do
            @(posedge clk);
        while (!in_ready);
        pred = predict_word(f, w, a, s);
        expected_results.push_back(typed ? typed_res : pred);
        words_sent++;
    endtask

    // Result checker: every accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        pin_result_t got;
        pin_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{scl, sda_out, sda_drive, busy_res, done_res, rdata, ack_ok, rejected};
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result word: scl=%0b sda=%0b drv=%0b",
                                       got.scl, got.sda_out, got.sda_drive));
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    note_failure($sformatf({"mismatch: exp scl=%0b sda=%0b drv=%0b busy=%0b ",
                                            "done=%0b rdata=%02h ack=%0b rej=%0b, got scl=%0b ",
                                            "sda=%0b drv=%0b busy=%0b done=%0b rdata=%02h ",
                                            "ack=%0b rej=%0b"},
                                           want.scl, want.sda_out, want.sda_drive, want.busy,
                                           want.done, want.rdata, want.ack_ok, want.rejected,
                                           got.scl, got.sda_out, got.sda_drive, got.busy,
                                           got.done, got.rdata, got.ack_ok, got.rejected));
            end
        end
    end

    // Output side: random stalls, mostly short, plus one long hold-off that
    // lets the internal queue fill so in_ready drops while words keep coming.
    initial
    begin
        int  r;
        int  len;
        bit  held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && words_sent >= HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_ready <= 1'b1;
                    len = $urandom_range(1, 30);
                end
                else
                begin
                    out_ready <= 1'b0;
                    if (r < 90)
                        len = $urandom_range(1, 3);
                    else if (r < 98)
                        len = $urandom_range(4, 12);
                    else
                        len = $urandom_range(20, 50);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   row;
        pin_result_t none;
        logic [2:0]  cmd;
        int          counted;
        int          len;
        int          r;
        none = '0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= FUNC_TICK;
        wdata     <= 8'h00;
        ack_level <= 1'b0;
        sda_in    <= 1'b0;

        // shadow state matches the reset state
        seq_op    = OP_IDLE;
        seq_step  = '0;
        shifter   = '0;
        ack_hold  = 1'b1;
        pin_scl   = 1'b1;
        pin_sda   = 1'b1;
        pin_drive = 1'b1;
        rd_byte   = '0;
        wr_ack_ok = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words. Rows with a typed result follow from reset at a glance;
        // the rest go through the predictor. reps repeats a row, used for tick runs.
        //      func          wdata  ack   sda   reps  typed result
        add_row(FUNC_TICK,    8'h00, 1'b0, 1'b0, 1,    1'b1, RES_RESET);       // tick while idle
        add_row(FUNC_SPARE_A, 8'hFF, 1'b1, 1'b1, 1,    1'b1, RES_RESET);       // unused codes
        add_row(FUNC_SPARE_B, 8'hFF, 1'b1, 1'b1, 1,    1'b1, RES_RESET);
        add_row(FUNC_START,   8'h00, 1'b0, 1'b0, 1,    1'b1, RES_LOADED);      // load, pins hold
        add_row(FUNC_READ,    8'hFF, 1'b1, 1'b1, 1,    1'b1, RES_REJECT_IDLE); // busy reject
        add_row(FUNC_TICK,    8'h00, 1'b0, 1'b0, LEN_START, 1'b0, none);
        add_row(FUNC_WRITE,   8'hFF, 1'b0, 1'b0, 1,    1'b0, none);
        add_row(FUNC_STOP,    8'h00, 1'b1, 1'b1, 1,    1'b1, RES_REJECT_LOW);
        add_row(FUNC_TICK,    8'h00, 1'b0, 1'b0, LEN_WRITE, 1'b0, none);       // ack seen
        add_row(FUNC_READ,    8'h00, 1'b1, 1'b0, 1,    1'b0, none);            // NACK after
        add_row(FUNC_TICK,    8'hFF, 1'b1, 1'b1, LEN_READ, 1'b0, none);        // reads 0xFF
        add_row(FUNC_RESTART, 8'h00, 1'b0, 1'b0, 1,    1'b0, none);
        add_row(FUNC_TICK,    8'h00, 1'b0, 1'b1, LEN_RESTART, 1'b0, none);
        add_row(FUNC_WRITE,   8'h00, 1'b0, 1'b1, 1,    1'b0, none);
        add_row(FUNC_TICK,    8'h00, 1'b0, 1'b1, LEN_WRITE, 1'b0, none);       // no ack
        add_row(FUNC_READ,    8'hFF, 1'b0, 1'b0, 1,    1'b0, none);            // ACK after
        add_row(FUNC_TICK,    8'h00, 1'b0, 1'b0, LEN_READ, 1'b0, none);        // reads 0x00
        add_row(FUNC_TICK,    8'hFF, 1'b1, 1'b1, 1,    1'b0, none);            // idle again
        add_row(FUNC_STOP,    8'h00, 1'b0, 1'b0, 1,    1'b0, none);
        add_row(FUNC_TICK,    8'h00, 1'b0, 1'b0, LEN_STOP, 1'b0, none);

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            repeat (row.reps)
                send_word(row.f, row.w, row.a, row.s, row.typed, row.res);
        end

        // Random part: mostly complete command sequences with random content,
        // some cut short, with stray commands mid-sequence and ignored words between.
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                cmd = (r < 4) ? FUNC_TICK : 3'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_B));
                send_word(cmd, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, none);
            end
            else
            begin
                cmd = 3'($urandom_range(FUNC_START, FUNC_READ));
                case (cmd)
                    FUNC_START:   len = LEN_START;
                    FUNC_RESTART: len = LEN_RESTART;
                    FUNC_STOP:    len = LEN_STOP;
                    FUNC_WRITE:   len = LEN_WRITE;
                    default:      len = LEN_READ;
                endcase
                if (r < 16)
                    len = $urandom_range(0, len - 1);   // broken sequence
                send_word(cmd, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, none);
                counted++;
                repeat (len)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_word(3'($urandom_range(FUNC_START, FUNC_READ)), 8'($urandom),
                                  1'($urandom), 1'($urandom), 1'b0, none);
                    send_word(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, none);
                    counted++;
                end
            end
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            note_failure("expected results left over at end of run");

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
